// ----- hdl/jmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// jmcs_pkg
// Types, codes and constants shared by the jog command sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package jmcs_pkg;

  // number of axes with sequencer state
  localparam int AXES = 8;
  localparam int AX_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

  // field widths
  localparam int AXIS_W = 3;
  localparam int DIST_W = 28;
  localparam int MOVE_W = DIST_W + 1;
  localparam int SPEED_W = 7;
  localparam int RQ_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = DIST_W;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JOG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DIST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JOG_SPEED = 2'd3;

  // jog modes (code 3 is unused and emits no move)
  localparam logic [1:0] MODE_STEP = 2'd0;
  localparam logic [1:0] MODE_DIST = 2'd1;
  localparam logic [1:0] MODE_CONT = 2'd2;

  // opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // request bit positions
  localparam int RQ_STOP = 0;
  localparam int RQ_FWD = 1;
  localparam int RQ_BWD = 2;
  localparam int RQ_HOME = 3;

  // distance used while a direction is held in continuous mode
  localparam logic [DIST_W-1:0] CONT_DIST = 28'hfffffff;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2,
    CMD_HOME = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PEND = 2'd1,
    PH_MOVING = 2'd2,
    PH_STOPPING = 2'd3
  } phase_e;

  typedef struct packed {
    cmd_e                      command;
    logic [AXIS_W-1:0]         target_axis;
    logic signed [MOVE_W-1:0]  move_distance;
    logic [SPEED_W-1:0]        move_speed;
    logic [RQ_W-1:0]           request_state;
    logic                      last;
  } res_t;

  // ten to the power of the step level
  function automatic logic [DIST_W-1:0] decade_dist(input logic [2:0] level);
    logic [DIST_W-1:0] d;
    case (level)
      3'd0: d = 28'd1;
      3'd1: d = 28'd10;
      3'd2: d = 28'd100;
      3'd3: d = 28'd1000;
      3'd4: d = 28'd10000;
      3'd5: d = 28'd100000;
      3'd6: d = 28'd1000000;
      3'd7: d = 28'd10000000;
      default: d = 28'd1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/jmcs_if.sv -----
// ----------------------------------------------------------------------------
// jmcs_in_if / jmcs_out_if
// Valid/ready channels for request items and command results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jmcs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] axis;
  logic       want_stop;
  logic       want_forward;
  logic       want_backward;
  logic       want_home;
  logic       axis_idle;

  modport source (output valid, opcode, axis, want_stop, want_forward, want_backward,
                  want_home, axis_idle, input ready);
  modport sink (input valid, opcode, axis, want_stop, want_forward, want_backward,
                want_home, axis_idle, output ready);
endinterface

interface jmcs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         target_axis;
  logic signed [28:0] move_distance;
  logic [6:0]         move_speed;
  logic [3:0]         request_state;
  logic               last;

  modport source (output valid, command, target_axis, move_distance, move_speed,
                  request_state, last, input ready);
  modport sink (input valid, command, target_axis, move_distance, move_speed,
                request_state, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/jmcs_res_fifo.sv -----
// ----------------------------------------------------------------------------
// jmcs_res_fifo
// Small result queue: takes one or two results a cycle, delivers one while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jmcs_res_fifo
  import jmcs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push0_i,
  input  wire logic  push1_i,
  input  wire res_t  res0_i,
  input  wire res_t  res1_i,
  output logic       space_o,
  jmcs_out_if.source out_o
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic [RES_PTR_W-1:0] wr_ptr_nx;
  logic                 pop;
  logic                 push1;
  res_t                 head;

  assign push1 = push0_i & push1_i;
  assign pop = out_o.valid & out_o.ready;
  assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

  // room for a two-result item
  assign space_o = (count_q <= RES_CNT_W'(RES_DEPTH - 2));

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push0_i) + RES_PTR_W'(push1);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop);
    count_d = count_q + RES_CNT_W'(push0_i) + RES_CNT_W'(push1) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push1) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  // head of queue drives the channel
  assign head = mem_q[rd_ptr_q];
  assign out_o.valid = (count_q != '0);
  assign out_o.command = head.command;
  assign out_o.target_axis = head.target_axis;
  assign out_o.move_distance = head.move_distance;
  assign out_o.move_speed = head.move_speed;
  assign out_o.request_state = head.request_state;
  assign out_o.last = head.last;

endmodule

`default_nettype wire

// ----- hdl/jog_motion_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// jog_motion_command_sequencer
// Per-axis jog request sequencer producing move, stop and homing commands.
// ----------------------------------------------------------------------------
// An accepted request is latched in an input register. From there its axis
// state is read and updated, and one or two results are written into a
// four-entry result queue, once the queue has room. The first result is
// offered on the output after it has passed the input register and been
// stored in the queue. A new request is taken every cycle while the queue
// holds at most two results. A request that yields both a homing and a move
// command gives two results, so the sustained rate is bounded by one result
// per cycle. Output stalls hold the input off once three or more results are
// waiting. Configuration writes are registered and must be made only while
// no requests are in flight.
`default_nettype none

module jog_motion_command_sequencer
  import jmcs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jmcs_in_if.sink                    in_i,
  jmcs_out_if.source                 out_o
);

  // configuration registers
  logic [1:0]         jog_mode_q;
  logic [2:0]         step_level_q;
  logic [DIST_W-1:0]  step_dist_q;
  logic [SPEED_W-1:0] jog_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jog_mode_q <= MODE_STEP;
      step_level_q <= '0;
      step_dist_q <= '0;
      jog_speed_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_JOG_MODE:   jog_mode_q <= cfg_wdata_i[1:0];
        REG_STEP_LEVEL: step_level_q <= cfg_wdata_i[2:0];
        REG_STEP_DIST:  step_dist_q <= cfg_wdata_i;
        REG_JOG_SPEED:  jog_speed_q <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [AXIS_W-1:0] s1_axis_q;
  logic [RQ_W-1:0]   s1_want_q;
  logic              s1_idle_q;
  logic              s1_fire;
  logic              fifo_space;

  assign s1_fire = s1_valid_q & fifo_space;
  assign in_i.ready = ~s1_valid_q | s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q <= in_i.opcode;
      s1_axis_q <= in_i.axis;
      s1_want_q <= {in_i.want_home, in_i.want_backward, in_i.want_forward, in_i.want_stop};
      s1_idle_q <= in_i.axis_idle;
    end
  end

  // per-axis state, read and written at the addressed axis
  phase_e          phase_q [AXES];
  logic            dir_q   [AXES];
  logic [RQ_W-1:0] rq_q    [AXES];

  logic                axis_ok;
  logic [AX_IDX_W-1:0] idx;
  phase_e              ph_rd;
  logic                dir_rd;
  logic [RQ_W-1:0]     rq_rd;

  assign axis_ok = (32'(s1_axis_q) < AXES);
  assign idx = AX_IDX_W'(s1_axis_q);
  assign ph_rd = phase_q[idx];
  assign dir_rd = dir_q[idx];
  assign rq_rd = rq_q[idx];

  // next axis state
  phase_e          ph_mid, ph_d;
  logic            dir_d;
  logic [RQ_W-1:0] rq_mid, rq_d;
  logic            home_emit;

  always_comb begin
    ph_mid = ph_rd;
    dir_d = dir_rd;
    rq_mid = rq_rd;
    home_emit = 1'b0;
    ph_d = ph_rd;
    rq_d = rq_rd;
    if (s1_op_q == OP_WRITE) begin
      rq_d = s1_want_q;
    end else if (rq_rd[RQ_STOP]) begin
      rq_d = '0;
      ph_d = PH_IDLE;
    end else begin
      if (ph_rd == PH_IDLE) begin
        if (rq_rd[RQ_FWD]) begin
          dir_d = 1'b0;
          ph_mid = PH_PEND;
        end
        if (rq_rd[RQ_BWD]) begin
          dir_d = 1'b1;
          ph_mid = PH_PEND;
        end
        if (rq_rd[RQ_HOME]) begin
          home_emit = 1'b1;
          rq_mid[RQ_HOME] = 1'b0;
        end
      end
      if (jog_mode_q != MODE_CONT) begin
        rq_mid[RQ_FWD] = 1'b0;
        rq_mid[RQ_BWD] = 1'b0;
      end
      ph_d = ph_mid;
      rq_d = rq_mid;
      case (ph_mid)
        PH_PEND: ph_d = PH_MOVING;
        PH_MOVING: begin
          if (jog_mode_q == MODE_STEP || jog_mode_q == MODE_DIST) begin
            if (s1_idle_q) begin
              ph_d = PH_IDLE;
              rq_d = '0;
            end
          end else if (jog_mode_q == MODE_CONT) begin
            if (!rq_mid[RQ_FWD] && !rq_mid[RQ_BWD]) begin
              ph_d = PH_STOPPING;
            end
          end
        end
        PH_STOPPING: begin
          if (jog_mode_q == MODE_STEP || jog_mode_q == MODE_DIST) begin
            if (s1_idle_q) begin
              ph_d = PH_IDLE;
              rq_d = '0;
            end
          end else if (jog_mode_q == MODE_CONT) begin
            if (s1_idle_q) begin
              ph_d = PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        phase_q[i] <= PH_IDLE;
        dir_q[i] <= 1'b0;
        rq_q[i] <= '0;
      end
    end else if (s1_fire && axis_ok) begin
      phase_q[idx] <= ph_d;
      dir_q[idx] <= dir_d;
      rq_q[idx] <= rq_d;
    end
  end

  // result generation
  logic              sec_emit;
  cmd_e              sec_cmd;
  logic [DIST_W-1:0] move_dist;
  logic [MOVE_W-1:0] dist_s;
  res_t              res0, res1;
  logic              push1;

  always_comb begin
    case (jog_mode_q)
      MODE_STEP: move_dist = decade_dist(step_level_q);
      MODE_DIST: move_dist = step_dist_q;
      MODE_CONT: move_dist = CONT_DIST;
      default:   move_dist = '0;
    endcase
    dist_s = dir_d ? (MOVE_W'(0) - MOVE_W'(move_dist)) : MOVE_W'(move_dist);
  end

  always_comb begin
    sec_emit = 1'b0;
    sec_cmd = CMD_NONE;
    if (axis_ok && s1_op_q == OP_SCAN) begin
      if (rq_rd[RQ_STOP]) begin
        sec_emit = 1'b1;
        sec_cmd = CMD_STOP;
      end else if (ph_mid == PH_PEND) begin
        if (jog_mode_q == MODE_STEP || jog_mode_q == MODE_DIST || jog_mode_q == MODE_CONT) begin
          sec_emit = 1'b1;
          sec_cmd = CMD_MOVE;
        end
      end else if (ph_mid == PH_MOVING && jog_mode_q == MODE_CONT &&
                   !rq_mid[RQ_FWD] && !rq_mid[RQ_BWD]) begin
        sec_emit = 1'b1;
        sec_cmd = CMD_STOP;
      end
    end
  end

  always_comb begin
    logic home_ok;
    home_ok = axis_ok && s1_op_q == OP_SCAN && !rq_rd[RQ_STOP] && home_emit;
    res1.command = sec_cmd;
    res1.target_axis = s1_axis_q;
    res1.move_distance = (sec_cmd == CMD_MOVE) ? dist_s : '0;
    res1.move_speed = (sec_cmd == CMD_MOVE) ? jog_speed_q : '0;
    res1.request_state = axis_ok ? rq_d : '0;
    res1.last = 1'b1;
    push1 = home_ok && sec_emit;
    if (home_ok) begin
      res0.command = CMD_HOME;
      res0.target_axis = s1_axis_q;
      res0.move_distance = '0;
      res0.move_speed = '0;
      res0.request_state = rq_d;
      res0.last = ~sec_emit;
    end else if (sec_emit) begin
      res0 = res1;
    end else begin
      res0 = res1;
      res0.command = CMD_NONE;
      res0.move_distance = '0;
      res0.move_speed = '0;
    end
  end

  jmcs_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (s1_fire),
    .push1_i (push1),
    .res0_i  (res0),
    .res1_i  (res1),
    .space_o (fifo_space),
    .out_o   (out_o)
  );

  // checks
  a_two_results_home_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && push1) |-> (res0.command == CMD_HOME && !res0.last && res1.last))
    else $error("two-result item not ordered home then move/stop");

  a_stop_idles_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && axis_ok && s1_op_q == OP_SCAN && rq_rd[RQ_STOP])
      |=> (phase_q[$past(idx)] == PH_IDLE && rq_q[$past(idx)] == '0))
    else $error("stop request did not return axis to idle");

  a_move_only_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && sec_cmd == CMD_MOVE) |=> (phase_q[$past(idx)] == PH_MOVING))
    else $error("move issued without entering moving phase");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-axis jog command sequencer. Request items
// (bit writes and axis scans) are queued by the stimulus process and driven
// by a clocked driver. A predictor tracks every axis's phase, direction and
// request bits and queues the expected commands. A clocked monitor compares
// each command with the oldest expected one. The run steps through the jog
// modes and register extremes under different sender and receiver idling.
// ----------------------------------------------------------------------------

module testbench;
  import jmcs_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES = 8;

  // mode code with no move behind it
  localparam logic [1:0] MODE_NONE = 2'd3;

  // request bit masks
  localparam logic [RQ_W-1:0] BIT_STOP = 4'b0001 << RQ_STOP;
  localparam logic [RQ_W-1:0] BIT_FWD = 4'b0001 << RQ_FWD;
  localparam logic [RQ_W-1:0] BIT_BWD = 4'b0001 << RQ_BWD;
  localparam logic [RQ_W-1:0] BIT_HOME = 4'b0001 << RQ_HOME;
  localparam logic [RQ_W-1:0] BIT_NONE = '0;

  typedef struct packed {
    logic              opcode;
    logic [AXIS_W-1:0] axis;
    logic              want_stop;
    logic              want_forward;
    logic              want_backward;
    logic              want_home;
    logic              axis_idle;
  } jog_req_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register port
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // channel drive
  logic     drv_valid = 1'b0;
  jog_req_t drv_req = '0;
  logic     sink_ready = 1'b0;

  jmcs_in_if  jog_req_if ();
  jmcs_out_if jog_cmd_if ();

  assign jog_req_if.valid = drv_valid;
  assign jog_req_if.opcode = drv_req.opcode;
  assign jog_req_if.axis = drv_req.axis;
  assign jog_req_if.want_stop = drv_req.want_stop;
  assign jog_req_if.want_forward = drv_req.want_forward;
  assign jog_req_if.want_backward = drv_req.want_backward;
  assign jog_req_if.want_home = drv_req.want_home;
  assign jog_req_if.axis_idle = drv_req.axis_idle;
  assign jog_cmd_if.ready = sink_ready;

  jog_motion_command_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (jog_req_if),
    .out_o      (jog_cmd_if)
  );

  // bench state
  jog_req_t pending_reqs[$];
  res_t     expected_cmds[$];
  int       req_count = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  jog_req_t next_req;

  // predictor copy of registers and axis state
  logic [1:0]         mode_q = MODE_STEP;
  logic [2:0]         level_q = '0;
  logic [DIST_W-1:0]  dist_q = '0;
  logic [SPEED_W-1:0] speed_q = '0;
  phase_e             axis_phase[AXES];
  logic               axis_dir[AXES];
  logic [RQ_W-1:0]    axis_rq[AXES];

  initial begin
    for (int a = 0; a < AXES; a++) begin
      axis_phase[a] = PH_IDLE;
      axis_dir[a] = 1'b0;
      axis_rq[a] = '0;
    end
  end

  function automatic logic [DIST_W-1:0] decade_step(input logic [2:0] lvl);
    logic [DIST_W-1:0] d;
    d = DIST_W'(1);
    for (int k = 0; k < lvl; k++) d = DIST_W'(d * 10);
    return d;
  endfunction

  function automatic res_t make_cmd(input cmd_e c, input logic [AXIS_W-1:0] ax,
                                    input logic signed [MOVE_W-1:0] d,
                                    input logic [SPEED_W-1:0] s);
    res_t r;
    r = '0;
    r.command = c;
    r.target_axis = ax;
    r.move_distance = d;
    r.move_speed = s;
    return r;
  endfunction

  // Work out the commands one request causes and queue them
  task automatic predict_commands(input jog_req_t r);
    res_t                     batch[$];
    res_t                     one;
    logic [RQ_W-1:0]          rq;
    logic signed [MOVE_W-1:0] mv;
    int                       ax;
    ax = int'(r.axis);
    if (r.opcode == OP_WRITE) begin
      rq = '0;
      rq[RQ_STOP] = r.want_stop;
      rq[RQ_FWD] = r.want_forward;
      rq[RQ_BWD] = r.want_backward;
      rq[RQ_HOME] = r.want_home;
      axis_rq[ax] = rq;
      batch.push_back(make_cmd(CMD_NONE, r.axis, '0, '0));
    end else begin
      rq = axis_rq[ax];
      if (rq[RQ_STOP]) begin
        // stop wins over everything and clears the axis
        rq = '0;
        axis_phase[ax] = PH_IDLE;
        batch.push_back(make_cmd(CMD_STOP, r.axis, '0, '0));
      end else begin
        if (axis_phase[ax] == PH_IDLE) begin
          if (rq[RQ_FWD]) begin
            axis_dir[ax] = 1'b0;
            axis_phase[ax] = PH_PEND;
          end
          // backward overrides forward
          if (rq[RQ_BWD]) begin
            axis_dir[ax] = 1'b1;
            axis_phase[ax] = PH_PEND;
          end
          if (rq[RQ_HOME]) begin
            batch.push_back(make_cmd(CMD_HOME, r.axis, '0, '0));
            rq[RQ_HOME] = 1'b0;
          end
        end
        // direction bits only persist while held in continuous mode
        if (mode_q != MODE_CONT) begin
          rq[RQ_FWD] = 1'b0;
          rq[RQ_BWD] = 1'b0;
        end
        case (axis_phase[ax])
          PH_PEND: begin
            axis_phase[ax] = PH_MOVING;
            if (mode_q != MODE_NONE) begin
              case (mode_q)
                MODE_STEP: mv = {1'b0, decade_step(level_q)};
                MODE_DIST: mv = {1'b0, dist_q};
                default: mv = {1'b0, CONT_DIST};
              endcase
              if (axis_dir[ax]) mv = -mv;
              batch.push_back(make_cmd(CMD_MOVE, r.axis, mv, speed_q));
            end
          end
          PH_MOVING: begin
            if (mode_q == MODE_STEP || mode_q == MODE_DIST) begin
              if (r.axis_idle) begin
                axis_phase[ax] = PH_IDLE;
                rq = '0;
              end
            end else if (mode_q == MODE_CONT) begin
              // direction released: stop the continuous move
              if (!rq[RQ_FWD] && !rq[RQ_BWD]) begin
                axis_phase[ax] = PH_STOPPING;
                batch.push_back(make_cmd(CMD_STOP, r.axis, '0, '0));
              end
            end
          end
          PH_STOPPING: begin
            if (mode_q == MODE_STEP || mode_q == MODE_DIST) begin
              if (r.axis_idle) begin
                axis_phase[ax] = PH_IDLE;
                rq = '0;
              end
            end else if (mode_q == MODE_CONT) begin
              if (r.axis_idle) axis_phase[ax] = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      axis_rq[ax] = rq;
      if (batch.size() == 0) batch.push_back(make_cmd(CMD_NONE, r.axis, '0, '0));
    end
    for (int i = 0; i < batch.size(); i++) begin
      one = batch[i];
      one.request_state = axis_rq[ax];
      one.last = (i == batch.size() - 1);
      expected_cmds.push_back(one);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Driver: next request is taken when the channel is free
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || jog_req_if.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        predict_commands(next_req);
        drv_req <= next_req;
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every accepted command with the oldest expected one
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && jog_cmd_if.valid && jog_cmd_if.ready) begin
      got.command = cmd_e'(jog_cmd_if.command);
      got.target_axis = jog_cmd_if.target_axis;
      got.move_distance = jog_cmd_if.move_distance;
      got.move_speed = jog_cmd_if.move_speed;
      got.request_state = jog_cmd_if.request_state;
      got.last = jog_cmd_if.last;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command %p", got));
      end else begin
        want = expected_cmds.pop_front();
        if (got.command !== want.command || got.target_axis !== want.target_axis ||
            got.move_distance !== want.move_distance ||
            got.move_speed !== want.move_speed ||
            got.request_state !== want.request_state || got.last !== want.last) begin
          report_mismatch($sformatf("expected %p got %p", want, got));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_JOG_MODE: mode_q = val[1:0];
      REG_STEP_LEVEL: level_q = val[2:0];
      REG_STEP_DIST: dist_q = val[DIST_W-1:0];
      default: speed_q = val[SPEED_W-1:0];
    endcase
  endtask

  task automatic configure(input logic [1:0] mode, input logic [2:0] lvl,
                           input logic [DIST_W-1:0] step_dist,
                           input logic [SPEED_W-1:0] spd);
    write_reg(REG_JOG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_STEP_LEVEL, CFG_DATA_W'(lvl));
    write_reg(REG_STEP_DIST, CFG_DATA_W'(step_dist));
    write_reg(REG_JOG_SPEED, CFG_DATA_W'(spd));
  endtask

  task automatic push_req(input jog_req_t r);
    pending_reqs.push_back(r);
    req_count++;
  endtask

  task automatic add_write(input logic [AXIS_W-1:0] ax, input logic [RQ_W-1:0] rq);
    jog_req_t r;
    r.opcode = OP_WRITE;
    r.axis = ax;
    r.want_stop = rq[RQ_STOP];
    r.want_forward = rq[RQ_FWD];
    r.want_backward = rq[RQ_BWD];
    r.want_home = rq[RQ_HOME];
    r.axis_idle = 1'($urandom_range(1));
    push_req(r);
  endtask

  // request bit fields are don't-care on a scan, so they are randomized
  task automatic add_scan(input logic [AXIS_W-1:0] ax, input logic idle);
    jog_req_t r;
    logic [RQ_W-1:0] junk;
    junk = RQ_W'($urandom_range(15));
    r.opcode = OP_SCAN;
    r.axis = ax;
    r.want_stop = junk[0];
    r.want_forward = junk[1];
    r.want_backward = junk[2];
    r.want_home = junk[3];
    r.axis_idle = idle;
    push_req(r);
  endtask

  // Well-formed jog: set bits, scan while moving, maybe stop or release,
  // then report the axis idle
  task automatic queue_jog_burst();
    logic [AXIS_W-1:0] ax;
    logic [RQ_W-1:0]   rq;
    ax = AXIS_W'($urandom_range(AXES - 1));
    rq = BIT_NONE;
    if ($urandom_range(99) < 10) rq |= BIT_STOP;
    if ($urandom_range(99) < 60) rq |= BIT_FWD;
    if ($urandom_range(99) < 40) rq |= BIT_BWD;
    if ($urandom_range(99) < 25) rq |= BIT_HOME;
    add_write(ax, rq);
    repeat ($urandom_range(1, 4)) add_scan(ax, $urandom_range(99) < 15);
    if ($urandom_range(99) < 20) begin
      add_write(ax, BIT_STOP);
      add_scan(ax, 1'b0);
    end else if ($urandom_range(99) < 60) begin
      add_write(ax, ($urandom_range(99) < 20) ? BIT_HOME : BIT_NONE);
      add_scan(ax, 1'b0);
    end
    repeat ($urandom_range(1, 2)) add_scan(ax, 1'b1);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || drv_valid || expected_cmds.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int idx);
    logic [31:0] raw;
    int          target;
    case (idx)
      0: configure(MODE_STEP, 3'd0, '0, 7'd0);
      1: configure(MODE_STEP, 3'd7, '1, 7'd100);
      2: configure(MODE_DIST, 3'($urandom_range(7)), '0, 7'($urandom_range(100)));
      3: configure(MODE_DIST, 3'd0, '1, 7'd100);
      4: configure(MODE_CONT, 3'd7, '0, 7'd1);
      5: configure(MODE_CONT, 3'($urandom_range(7)), DIST_W'($urandom()),
                   7'($urandom_range(100)));
      6: configure(MODE_NONE, 3'd3, DIST_W'($urandom()), 7'd100);
      default: configure(MODE_STEP, 3'($urandom_range(7)), DIST_W'($urandom()),
                         7'($urandom_range(100)));
    endcase
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
    target = req_count + ITEMS_PER_PHASE;
    while (req_count < target) begin
      if ($urandom_range(99) < 15) begin
        raw = $urandom();
        push_req(raw[$bits(jog_req_t)-1:0]);
      end else begin
        queue_jog_burst();
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: step mode at the largest decade and full speed
    configure(MODE_STEP, 3'd7, '1, 7'd100);
    add_write(3'd0, BIT_FWD);
    add_scan(3'd0, 1'b0);
    add_scan(3'd0, 1'b0);
    add_scan(3'd0, 1'b1);
    // both directions: backward wins
    add_write(3'd7, BIT_FWD | BIT_BWD);
    add_scan(3'd7, 1'b0);
    add_scan(3'd7, 1'b1);
    // home with a move gives two commands
    add_write(3'd1, BIT_HOME | BIT_FWD);
    add_scan(3'd1, 1'b0);
    add_scan(3'd1, 1'b1);
    // stop overrides all other bits
    add_write(3'd2, BIT_STOP | BIT_FWD | BIT_BWD | BIT_HOME);
    add_scan(3'd2, 1'b0);
    add_write(3'd3, BIT_HOME);
    add_scan(3'd3, 1'b1);
    add_scan(3'd4, 1'b0);
    add_write(3'd5, BIT_NONE);
    // stop while moving
    add_write(3'd6, BIT_BWD);
    add_scan(3'd6, 1'b0);
    add_write(3'd6, BIT_STOP);
    add_scan(3'd6, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    repeat (10) @(posedge clk_i);
    mismatch_cnt += expected_cmds.size();
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- jog_motion_command_sequencer.f -----
hdl/jmcs_pkg.sv
hdl/jmcs_if.sv
hdl/jmcs_res_fifo.sv
hdl/jog_motion_command_sequencer.sv
tb/testbench.sv
